// File: rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

	localparam int KEY_W = 32;
	localparam int PAY_W = 32;
	localparam int URG_W = 3;
	localparam int POS_W = 5;
	localparam int OP_W  = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_POP    = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		logic [URG_W-1:0] urgency;
	} entry_t;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [KEY_W-1:0] item_key;
		logic [PAY_W-1:0] item_payload;
		logic [URG_W-1:0] item_urgency;
	} req_item_t;

	typedef struct packed {
		logic             ok;
		logic [KEY_W-1:0] out_key;
		logic [PAY_W-1:0] out_payload;
		logic [URG_W-1:0] out_urgency;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] occupancy;
	} rsp_item_t;

	typedef struct packed {
		logic insert;
		logic pop;
		entry_t ent;
	} cell_cmd_t;

	typedef struct packed {
		logic             found;
		logic [KEY_W-1:0] key;
		entry_t           ent;
		logic [POS_W-1:0] pos;
	} search_pkt_t;

endpackage

`default_nettype wire

// File: rtl/spq_req_if.sv
`default_nettype none

interface spq_req_if;
	logic               valid;
	logic               ready;
	spq_pkg::req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// File: rtl/spq_rsp_if.sv
`default_nettype none

interface spq_rsp_if;
	logic               valid;
	logic               ready;
	spq_pkg::rsp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// File: rtl/spq_cell.sv
`default_nettype none

module spq_cell #(
	parameter int IDX  = 0,
	parameter int CNTW = 5
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  spq_pkg::cell_cmd_t        cmd,
	input  wire [CNTW-1:0]            cnt,
	input  spq_pkg::entry_t           left_ent,
	input  wire                       left_keep,
	input  spq_pkg::entry_t           right_ent,
	input  wire                       left_act,
	input  spq_pkg::search_pkt_t      left_pkt,
	output spq_pkg::entry_t           ent,
	output logic                      keep,
	output logic                      act,
	output spq_pkg::search_pkt_t      pkt
);

	spq_pkg::entry_t      ent_q;
	spq_pkg::search_pkt_t pkt_q;
	spq_pkg::search_pkt_t pkt_nxt;
	logic                 act_q;
	logic                 occupied;
	logic                 hit;

	assign occupied = CNTW'(IDX) < cnt;
	assign keep     = occupied && (ent_q.urgency >= cmd.ent.urgency);
	assign hit      = left_act && !left_pkt.found && occupied && (ent_q.key == left_pkt.key);

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (!keep) begin
				ent_q <= left_keep ? cmd.ent : left_ent;
			end
		end else if (cmd.pop) begin
			ent_q <= right_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= left_act;
		end
	end

	always_comb begin
		pkt_nxt = left_pkt;
		if (hit) begin
			pkt_nxt.found = 1'b1;
			pkt_nxt.ent   = ent_q;
			pkt_nxt.pos   = spq_pkg::POS_W'(IDX + 1);
		end
	end

	always_ff @(posedge clk) begin
		pkt_q <= pkt_nxt;
	end

	assign ent = ent_q;
	assign act = act_q;
	assign pkt = pkt_q;

endmodule

`default_nettype wire

// File: rtl/stable_priority_queue.sv
// Channel  Role    Handshake     Payload
// req      sink    valid/ready   operation, item_key, item_payload, item_urgency
// rsp      source  valid/ready   ok, out_key, out_payload, out_urgency, position, occupancy
//
// Insert and pop update the cell row at the accepting edge, which also registers the
// result, so the result is offered in the next cycle.
// A search travels down the row one cell per cycle, so its result is registered once it
// has passed the register of every cell, and no item is accepted meanwhile.
// A new item is accepted while the result register is empty or being drained.
// Reset empties the queue; entry contents are not cleared.
`default_nettype none

module stable_priority_queue #(
	parameter int DEPTH = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	localparam int CNTW = $clog2(DEPTH + 1);

	logic [CNTW-1:0]      cnt_q;
	logic [CNTW-1:0]      cnt_nxt;
	logic                 busy_q;
	logic                 rsp_valid_q;
	spq_pkg::rsp_item_t   rsp_item_q;
	spq_pkg::rsp_item_t   rsp_nxt;
	logic                 accept;
	logic                 full;
	logic                 empty;
	spq_pkg::cell_cmd_t   cmd;
	spq_pkg::search_pkt_t launch_pkt;
	logic                 launch;

	spq_pkg::entry_t      ent_w  [DEPTH];
	logic                 keep_w [DEPTH];
	logic [DEPTH-1:0]     act_w;
	spq_pkg::search_pkt_t pkt_w  [DEPTH];

	assign full      = cnt_q == CNTW'(DEPTH);
	assign empty     = cnt_q == '0;
	assign req.ready = !busy_q && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign cmd.insert      = accept && (req.item.operation == spq_pkg::OP_INSERT) && !full;
	assign cmd.pop         = accept && (req.item.operation == spq_pkg::OP_POP) && !empty;
	assign cmd.ent.key     = req.item.item_key;
	assign cmd.ent.payload = req.item.item_payload;
	assign cmd.ent.urgency = req.item.item_urgency;

	assign launch           = accept && (req.item.operation == spq_pkg::OP_SEARCH);
	assign launch_pkt.found = 1'b0;
	assign launch_pkt.key   = req.item.item_key;
	assign launch_pkt.ent   = '0;
	assign launch_pkt.pos   = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_cell #(
			.IDX  (i),
			.CNTW (CNTW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.cnt       (cnt_q),
			.left_ent  ((i == 0) ? cmd.ent : ent_w[(i == 0) ? 0 : i - 1]),
			.left_keep ((i == 0) ? 1'b1 : keep_w[(i == 0) ? 0 : i - 1]),
			.right_ent (ent_w[(i == DEPTH - 1) ? i : i + 1]),
			.left_act  ((i == 0) ? launch : act_w[(i == 0) ? 0 : i - 1]),
			.left_pkt  ((i == 0) ? launch_pkt : pkt_w[(i == 0) ? 0 : i - 1]),
			.ent       (ent_w[i]),
			.keep      (keep_w[i]),
			.act       (act_w[i]),
			.pkt       (pkt_w[i])
		);
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (cmd.insert) begin
			cnt_nxt = cnt_q + CNTW'(1);
		end else if (cmd.pop) begin
			cnt_nxt = cnt_q - CNTW'(1);
		end
	end

	always_comb begin
		rsp_nxt           = '0;
		rsp_nxt.occupancy = spq_pkg::POS_W'(cnt_nxt);
		if (act_w[DEPTH-1]) begin
			rsp_nxt.ok          = pkt_w[DEPTH-1].found;
			rsp_nxt.out_key     = pkt_w[DEPTH-1].ent.key;
			rsp_nxt.out_payload = pkt_w[DEPTH-1].ent.payload;
			rsp_nxt.out_urgency = pkt_w[DEPTH-1].ent.urgency;
			rsp_nxt.position    = pkt_w[DEPTH-1].pos;
		end else begin
			case (req.item.operation)
				spq_pkg::OP_INSERT: begin
					rsp_nxt.ok = !full;
				end
				spq_pkg::OP_POP: begin
					if (!empty) begin
						rsp_nxt.ok          = 1'b1;
						rsp_nxt.out_key     = ent_w[0].key;
						rsp_nxt.out_payload = ent_w[0].payload;
						rsp_nxt.out_urgency = ent_w[0].urgency;
					end
				end
				default: begin
					rsp_nxt.ok = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (launch) begin
				busy_q <= 1'b1;
			end else if (act_w[DEPTH-1]) begin
				busy_q <= 1'b0;
			end
			if ((accept && !launch) || act_w[DEPTH-1]) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((accept && !launch) || act_w[DEPTH-1]) begin
			rsp_item_q <= rsp_nxt;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.item  = rsp_item_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(DEPTH))
		else $error("entry count exceeds depth");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.ready)
		else $error("item accepted while a search is in flight");

	a_one_search: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(act_w))
		else $error("more than one search in the cell row");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> cnt_q == $past(cnt_q) - CNTW'(1))
		else $error("pop did not lower the count");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> cnt_q == $past(cnt_q) + CNTW'(1))
		else $error("insert did not raise the count");
`endif

endmodule

`default_nettype wire
